/* rtl/d2bwf_pkg.sv */
`default_nettype none

package d2bwf_pkg;

  localparam int WORD_W     = 64;
  localparam int IDX_W      = 6;
  localparam int EXP_W      = 11;
  localparam int LEAD_W     = 12;
  localparam int CFG_IDX_W  = 8;
  localparam int TUSER_W    = IDX_W + 1;

  localparam int WORDS_DEFAULT = 32;
  localparam int MIN_LEAD      = 6 + 17;
  localparam int HIDDEN_BIT    = 52;

  localparam logic [EXP_W-1:0]  EXP_ALL_ONES = 11'd2047;
  localparam logic [WORD_W-1:0] BIAS_RESET   = 64'd1073741824;
  localparam logic [WORD_W-1:0] MARKER_RESET = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIAS_WORD  = 8'd0,
    CFG_BAD_MARKER = 8'd1
  } cfg_reg_e;

endpackage

`default_nettype wire

/* rtl/double_to_biased_wide_fixed_top.sv */
`default_nettype none

// Converts each IEEE double bit pattern on the slave stream into WORDS 64-bit words of a
// biased wide unsigned fixed-point number, most significant word first, one word per
// cycle unless the master side stalls; tlast marks the least significant word and tuser
// carries the word index and an error flag (NaN, infinity or too large an exponent:
// word 0 is the bad marker, the rest zero). A double is decoded into a holding register
// when it is accepted, and a word generator with a single 64-bit add/subtract then
// fills the output register. The next double is taken in the cycle its predecessor's
// last word is generated. The bias and bad-marker registers are written through the
// cfg port, which is always ready; writes to other indexes are ignored.
module double_to_biased_wide_fixed_top #(
  parameter int WORDS = d2bwf_pkg::WORDS_DEFAULT
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [d2bwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [d2bwf_pkg::WORD_W-1:0]      cfg_data,

  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [63:0] value_bits
  input  wire logic [d2bwf_pkg::WORD_W-1:0]      s_axis_tdata,

  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [63:0] word
  output logic [d2bwf_pkg::WORD_W-1:0]           m_axis_tdata,
  output logic                                   m_axis_tlast,
  // [5:0] word_index, [6] error
  output logic [d2bwf_pkg::TUSER_W-1:0]          m_axis_tuser
);

  import d2bwf_pkg::*;

  localparam int TOP_BITS  = (WORDS - 1) * 64;
  localparam int MAX_SHIFT = TOP_BITS - MIN_LEAD;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORDS - 1);

  // config registers
  logic [WORD_W-1:0] bias_q, marker_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q   <= BIAS_RESET;
      marker_q <= MARKER_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BIAS_WORD:  bias_q   <= cfg_data;
        CFG_BAD_MARKER: marker_q <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode of the incoming double
  logic [EXP_W-1:0]  expo;
  logic [EXP_W-1:0]  shift;
  logic [WORD_W-1:0] mant;
  logic [LEAD_W-1:0] lead;
  logic [IDX_W-1:0]  fw;
  logic [5:0]        r;
  logic              err_d;
  logic [WORD_W-1:0] hi_d, lo_d;

  always_comb begin
    expo  = s_axis_tdata[62:52];
    shift = (expo <= EXP_W'(1)) ? '0 : expo - EXP_W'(1);
    mant  = {12'd0, s_axis_tdata[51:0]};
    mant[HIDDEN_BIT] = (expo != '0);
    lead  = LEAD_W'(TOP_BITS) - {1'b0, shift};
    fw    = lead[LEAD_W-1:6];
    r     = lead[5:0];
    err_d = (expo == EXP_ALL_ONES) || ({1'b0, shift} > LEAD_W'(MAX_SHIFT));
    hi_d  = mant >> r;
    lo_d  = ((r == '0) || (fw == LAST_IDX)) ? '0 : (mant << (6'd0 - r));
  end

  // item holding register
  logic              a_valid_q;
  logic              a_err_q, a_neg_q, a_hi_nz_q, a_lo_nz_q;
  logic [WORD_W-1:0] a_hi_q, a_lo_q;
  logic [IDX_W-1:0]  a_fw_q;
  logic [IDX_W-1:0]  cnt_q;

  logic out_valid_q;
  logic produce, a_done, s_accept;

  assign produce       = a_valid_q && (!out_valid_q || m_axis_tready);
  assign a_done        = produce && (cnt_q == LAST_IDX);
  assign s_axis_tready = !a_valid_q || a_done;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else if (s_accept) begin
      a_valid_q <= 1'b1;
      cnt_q     <= '0;
    end else if (a_done) begin
      a_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else if (produce) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      a_err_q   <= err_d;
      a_neg_q   <= s_axis_tdata[63];
      a_hi_q    <= hi_d;
      a_lo_q    <= lo_d;
      a_hi_nz_q <= (hi_d != '0);
      a_lo_nz_q <= (lo_d != '0);
      a_fw_q    <= fw;
    end
  end

  // word generator
  logic [WORD_W-1:0] mag, base, word_d;
  logic              at_hi, at_lo, borrow;

  always_comb begin
    at_hi  = (cnt_q == a_fw_q);
    at_lo  = ({1'b0, cnt_q} == ({1'b0, a_fw_q} + 7'd1));
    mag    = at_hi ? a_hi_q : (at_lo ? a_lo_q : '0);
    borrow = ((cnt_q <= a_fw_q) && a_lo_nz_q) || ((cnt_q < a_fw_q) && a_hi_nz_q);
    base   = (cnt_q == '0) ? bias_q : '0;
    if (a_err_q) begin
      word_d = (cnt_q == '0) ? marker_q : '0;
    end else if (a_neg_q) begin
      word_d = base - mag - {63'd0, borrow};
    end else begin
      word_d = base + mag;
    end
  end

  // output register
  logic [WORD_W-1:0] out_word_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_last_q, out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (produce) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (produce) begin
      out_word_q <= word_d;
      out_idx_q  <= cnt_q;
      out_last_q <= (cnt_q == LAST_IDX);
      out_err_q  <= a_err_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_err_q, out_idx_q};

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LAST_IDX)
    else $error("word counter past last word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> a_valid_q && (cnt_q == '0))
    else $error("accepted item not loaded at word zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[IDX_W-1:0] == LAST_IDX)))
    else $error("tlast does not match word index");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser[IDX_W] && (m_axis_tuser[IDX_W-1:0] != '0))
      |-> (m_axis_tdata == '0))
    else $error("error conversion with nonzero lower word");
`endif

endmodule

`default_nettype wire
